### hdl/rgbgfsc_pkg.sv
`timescale 1ns / 1ps

package rgbgfsc_pkg;

   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int REG_INDEX_WIDTH = 3;

   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      CSR_FRAME_ROWS      = 3'd0,
      CSR_FRAME_COLS      = 3'd1,
      CSR_RED_GAIN        = 3'd2,
      CSR_GREEN_GAIN      = 3'd3,
      CSR_BLUE_GAIN       = 3'd4,
      CSR_COMMIT_SEQUENCE = 3'd5,
      CSR_BYPASS_ENABLE   = 3'd6
   } csr_index_type;

   localparam logic [15:0] FRAME_ROWS_RESET = 16'd1080;
   localparam logic [15:0] FRAME_COLS_RESET = 16'd1920;
   localparam logic [15:0] GAIN_ONE         = 16'd256;
   localparam logic [23:0] ROUND_HALF       = 24'd128;
   localparam logic [7:0]  PIX_MAX          = 8'd255;
   localparam logic [31:0] CNT_MAX          = 32'hFFFF_FFFF;

   // unsigned Q8.8 gain, round to nearest, clamp to 8 bits
   function automatic logic [7:0] apply_gain(input logic [7:0] pix, input logic [15:0] gain);
      logic [23:0] prod;
      logic [15:0] scaled;
      prod   = 24'(pix) * 24'(gain) + ROUND_HALF;
      scaled = prod[23:8];
      return (scaled > 16'(PIX_MAX)) ? PIX_MAX : scaled[7:0];
   endfunction

endpackage

### hdl/rgb_gain_frame_sync_commit.sv
`timescale 1ns / 1ps

// channel    direction  handshake                    word
// req        in         req_valid / req_stall        req_in_red, req_in_green, req_in_blue
// rsp        out        rsp_valid / rsp_stall        rsp_out_* pixel, marks, status
// csr        in/out     csr_psel / csr_penable       csr_paddr, csr_pwdata, csr_prdata
//
// one word per clock unless the result stalls; a taken word goes to the input stage,
// then the result register (input stage holds gains and marks, multipliers sit before it)
// reset sets config defaults and unity active gains, clears position, counters and valids
// rsp_stall holds the result register; req_stall rises only while both stages are full
// and the result is stalled

module rgb_gain_frame_sync_commit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_in_red,
   input  logic [7:0]                             req_in_green,
   input  logic [7:0]                             req_in_blue,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_out_red,
   output logic [7:0]                             rsp_out_green,
   output logic [7:0]                             rsp_out_blue,
   output logic                                   rsp_start_of_frame,
   output logic                                   rsp_end_of_line,
   output logic [31:0]                            rsp_status_frames,
   output logic [31:0]                            rsp_status_commits,
   output logic [31:0]                            rsp_status_sequence_seen,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [rgbgfsc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rgbgfsc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rgbgfsc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                   csr_pready
);

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] red_gain;
      logic [15:0] green_gain;
      logic [15:0] blue_gain;
      logic        bypass;
      logic        sof;
      logic        eol;
      logic [31:0] frames;
      logic [31:0] commits;
      logic [31:0] sequence_seen;
   } stage_type;

   // configuration registers
   logic [15:0] frame_rows_ff;
   logic [15:0] frame_cols_ff;
   logic [15:0] red_gain_ff;
   logic [15:0] green_gain_ff;
   logic [15:0] blue_gain_ff;
   logic [31:0] commit_sequence_ff;
   logic        bypass_enable_ff;

   // frame state
   logic [15:0] column_ff,         column_in;
   logic [15:0] row_ff,            row_in;
   logic [15:0] active_red_ff,     active_red_in;
   logic [15:0] active_green_ff,   active_green_in;
   logic [15:0] active_blue_ff,    active_blue_in;
   logic [31:0] latched_seq_ff,    latched_seq_in;
   logic        seq_valid_ff,      seq_valid_in;
   logic [31:0] frame_count_ff,    frame_count_in;
   logic [31:0] commit_count_ff,   commit_count_in;
   logic [31:0] snap_frames_ff,    snap_frames_in;
   logic [31:0] snap_commits_ff,   snap_commits_in;
   logic [31:0] snap_sequence_ff,  snap_sequence_in;

   // pipeline
   stage_type   s1_ff,             s1_in;
   logic        s1_valid_ff,       s1_valid_in;
   logic        rsp_valid_ff,      rsp_valid_in;
   logic [7:0]  rsp_red_ff,        rsp_red_in;
   logic [7:0]  rsp_green_ff,      rsp_green_in;
   logic [7:0]  rsp_blue_ff,       rsp_blue_in;
   logic        rsp_sof_ff;
   logic        rsp_eol_ff;
   logic [31:0] rsp_frames_ff;
   logic [31:0] rsp_commits_ff;
   logic [31:0] rsp_sequence_ff;

   logic [rgbgfsc_pkg::REG_INDEX_WIDTH-1:0] csr_index;
   logic        csr_write;
   logic        req_accept;
   logic        out_free;
   logic        s1_move;
   logic [15:0] last_col;
   logic [15:0] last_row;
   logic        sof;
   logic        eol;
   logic        frame_end;
   logic        do_commit;

   // ---------------- configuration port ----------------

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[rgbgfsc_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff      <= rgbgfsc_pkg::FRAME_ROWS_RESET;
         frame_cols_ff      <= rgbgfsc_pkg::FRAME_COLS_RESET;
         red_gain_ff        <= rgbgfsc_pkg::GAIN_ONE;
         green_gain_ff      <= rgbgfsc_pkg::GAIN_ONE;
         blue_gain_ff       <= rgbgfsc_pkg::GAIN_ONE;
         commit_sequence_ff <= '0;
         bypass_enable_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            rgbgfsc_pkg::CSR_FRAME_ROWS:      frame_rows_ff      <= csr_pwdata[15:0];
            rgbgfsc_pkg::CSR_FRAME_COLS:      frame_cols_ff      <= csr_pwdata[15:0];
            rgbgfsc_pkg::CSR_RED_GAIN:        red_gain_ff        <= csr_pwdata[15:0];
            rgbgfsc_pkg::CSR_GREEN_GAIN:      green_gain_ff      <= csr_pwdata[15:0];
            rgbgfsc_pkg::CSR_BLUE_GAIN:       blue_gain_ff       <= csr_pwdata[15:0];
            rgbgfsc_pkg::CSR_COMMIT_SEQUENCE: commit_sequence_ff <= csr_pwdata[31:0];
            rgbgfsc_pkg::CSR_BYPASS_ENABLE:   bypass_enable_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rgbgfsc_pkg::CSR_FRAME_ROWS:      csr_prdata = 32'(frame_rows_ff);
         rgbgfsc_pkg::CSR_FRAME_COLS:      csr_prdata = 32'(frame_cols_ff);
         rgbgfsc_pkg::CSR_RED_GAIN:        csr_prdata = 32'(red_gain_ff);
         rgbgfsc_pkg::CSR_GREEN_GAIN:      csr_prdata = 32'(green_gain_ff);
         rgbgfsc_pkg::CSR_BLUE_GAIN:       csr_prdata = 32'(blue_gain_ff);
         rgbgfsc_pkg::CSR_COMMIT_SEQUENCE: csr_prdata = commit_sequence_ff;
         rgbgfsc_pkg::CSR_BYPASS_ENABLE:   csr_prdata = 32'(bypass_enable_ff);
         default:                          csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // ---------------- frame tracking and commit ----------------

   // a size of zero wraps to the full 16-bit range
   assign last_col  = frame_cols_ff - 16'd1;
   assign last_row  = frame_rows_ff - 16'd1;
   assign sof       = (column_ff == 16'd0) && (row_ff == 16'd0);
   assign eol       = (column_ff == last_col);
   assign frame_end = eol && (row_ff == last_row);
   assign do_commit = sof && (!seq_valid_ff || (commit_sequence_ff != latched_seq_ff));

   always_comb begin
      column_in       = eol ? 16'd0 : column_ff + 16'd1;
      row_in          = row_ff;
      if (eol) begin
         row_in = (row_ff == last_row) ? 16'd0 : row_ff + 16'd1;
      end

      active_red_in   = do_commit ? red_gain_ff        : active_red_ff;
      active_green_in = do_commit ? green_gain_ff      : active_green_ff;
      active_blue_in  = do_commit ? blue_gain_ff       : active_blue_ff;
      latched_seq_in  = do_commit ? commit_sequence_ff : latched_seq_ff;
      seq_valid_in    = seq_valid_ff || do_commit;

      commit_count_in = commit_count_ff;
      if (do_commit && (commit_count_ff != rgbgfsc_pkg::CNT_MAX)) begin
         commit_count_in = commit_count_ff + 32'd1;
      end
      frame_count_in = frame_count_ff;
      if (frame_end && (frame_count_ff != rgbgfsc_pkg::CNT_MAX)) begin
         frame_count_in = frame_count_ff + 32'd1;
      end

      // the last pixel of a frame already carries the new snapshot
      snap_frames_in   = frame_end ? frame_count_in  : snap_frames_ff;
      snap_commits_in  = frame_end ? commit_count_in : snap_commits_ff;
      snap_sequence_in = frame_end ? latched_seq_in  : snap_sequence_ff;

      s1_in.red           = req_in_red;
      s1_in.green         = req_in_green;
      s1_in.blue          = req_in_blue;
      s1_in.red_gain      = active_red_in;
      s1_in.green_gain    = active_green_in;
      s1_in.blue_gain     = active_blue_in;
      s1_in.bypass        = bypass_enable_ff;
      s1_in.sof           = sof;
      s1_in.eol           = eol;
      s1_in.frames        = snap_frames_in;
      s1_in.commits       = snap_commits_in;
      s1_in.sequence_seen = snap_sequence_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff        <= '0;
         row_ff           <= '0;
         active_red_ff    <= rgbgfsc_pkg::GAIN_ONE;
         active_green_ff  <= rgbgfsc_pkg::GAIN_ONE;
         active_blue_ff   <= rgbgfsc_pkg::GAIN_ONE;
         latched_seq_ff   <= '0;
         seq_valid_ff     <= 1'b0;
         frame_count_ff   <= '0;
         commit_count_ff  <= '0;
         snap_frames_ff   <= '0;
         snap_commits_ff  <= '0;
         snap_sequence_ff <= '0;
      end else if (req_accept) begin
         column_ff        <= column_in;
         row_ff           <= row_in;
         active_red_ff    <= active_red_in;
         active_green_ff  <= active_green_in;
         active_blue_ff   <= active_blue_in;
         latched_seq_ff   <= latched_seq_in;
         seq_valid_ff     <= seq_valid_in;
         frame_count_ff   <= frame_count_in;
         commit_count_ff  <= commit_count_in;
         snap_frames_ff   <= snap_frames_in;
         snap_commits_ff  <= snap_commits_in;
         snap_sequence_ff <= snap_sequence_in;
      end
   end

   // ---------------- gain stage ----------------

   always_comb begin
      rsp_red_in   = s1_ff.bypass ? s1_ff.red   :
                     rgbgfsc_pkg::apply_gain(s1_ff.red, s1_ff.red_gain);
      rsp_green_in = s1_ff.bypass ? s1_ff.green :
                     rgbgfsc_pkg::apply_gain(s1_ff.green, s1_ff.green_gain);
      rsp_blue_in  = s1_ff.bypass ? s1_ff.blue  :
                     rgbgfsc_pkg::apply_gain(s1_ff.blue, s1_ff.blue_gain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_red_ff      <= rsp_red_in;
         rsp_green_ff    <= rsp_green_in;
         rsp_blue_ff     <= rsp_blue_in;
         rsp_sof_ff      <= s1_ff.sof;
         rsp_eol_ff      <= s1_ff.eol;
         rsp_frames_ff   <= s1_ff.frames;
         rsp_commits_ff  <= s1_ff.commits;
         rsp_sequence_ff <= s1_ff.sequence_seen;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_out_red              = rsp_red_ff;
   assign rsp_out_green            = rsp_green_ff;
   assign rsp_out_blue             = rsp_blue_ff;
   assign rsp_start_of_frame       = rsp_sof_ff;
   assign rsp_end_of_line          = rsp_eol_ff;
   assign rsp_status_frames        = rsp_frames_ff;
   assign rsp_status_commits       = rsp_commits_ff;
   assign rsp_status_sequence_seen = rsp_sequence_ff;

   // ---------------- assertions ----------------

   a_commit_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (commit_count_ff >= $past(commit_count_ff)))
      else $error("commit count went backwards");

   a_sof_latches_sequence: assert property (@(posedge clock) disable iff (reset)
      (req_accept && sof) |=> (seq_valid_ff && (latched_seq_ff == $past(commit_sequence_ff))))
      else $error("frame start did not latch the commit sequence");

   a_eol_wraps_column: assert property (@(posedge clock) disable iff (reset)
      (req_accept && eol) |=> (column_ff == 16'd0))
      else $error("column did not wrap at end of line");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("input stage word lost while result stalled");

endmodule
